// ----- hdl/ap3d_pkg.sv -----
`timescale 1ns / 1ps

package ap3d_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CHAN_OUT_W = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 7;
	localparam int EXT_REG_W = 7;
	localparam int CH_REG_W = 5;
	localparam int POOL_REG_W = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EXTENT_D1     = 3'd0,
		REG_EXTENT_D2     = 3'd1,
		REG_EXTENT_D3     = 3'd2,
		REG_CHANNEL_COUNT = 3'd3,
		REG_POOL_D1       = 3'd4,
		REG_POOL_D2       = 3'd5,
		REG_POOL_D3       = 3'd6,
		REG_NONE          = 3'd7
	} reg_idx_t;

	localparam logic [EXT_REG_W-1:0]  EXT_RESET = 7'd8;
	localparam logic [CH_REG_W-1:0]   CH_RESET = 5'd1;
	localparam logic [POOL_REG_W-1:0] POOL_RESET = 4'd2;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_ACC  = 2'd1,
		ST_DIV  = 2'd2,
		ST_OUT  = 2'd3
	} state_t;

endpackage

// ----- hdl/average_pool_3d_stream.sv -----
`timescale 1ns / 1ps

// Streaming non-overlapping 3D average pooling.
// Input channel s_*: one signed Q7.8 sample per request, raster order with
// channel fastest, then d3, d2, d1. Output channel m_*: one window average
// per completed window, with its channel index; tlast marks the final
// average of the volume.
// Config channel cfg_*: register index and data; a write to a known index
// also restarts the volume. Write only while the block is idle.
// Per-channel window sums for one plane of output cells live in a
// synchronous memory, read on accept and written back in the next cycle.
// A sample that completes no window passes through the idle and accumulate
// states; one that completes a window then waits in the bit-serial divider
// that forms the rounded average, and then in the output state.
// The output register holds a result while the receiver stalls; the next
// sample is taken meanwhile, and only a second finished average waits.
// Reset restores register defaults and the start-of-volume position; the
// sum memory is not cleared, since the first sample of each window
// overwrites its entry.
module average_pool_3d_stream #(
	parameter int MAX_EXTENT = 64,
	parameter int MAX_CHANNELS = 16,
	parameter int MAX_POOL = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [15:0] pooled_value, [19:16] out_channel
	output logic        m_tlast,   // volume_done
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	localparam int PW = $clog2(MAX_EXTENT);
	localparam int EW = $clog2(MAX_EXTENT + 1);
	localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int NCW = $clog2(MAX_CHANNELS + 1);
	localparam int OW = $clog2(MAX_POOL);
	localparam int PLW = $clog2(MAX_POOL + 1);
	localparam int NMAX = MAX_POOL * MAX_POOL * MAX_POOL;
	localparam int NW = $clog2(NMAX + 1);
	localparam int SUM_W = ap3d_pkg::SAMPLE_W + $clog2(NMAX);
	localparam int DW = SUM_W + 1;
	localparam int VW = NW + 1;
	localparam int AW = PW + PW + CW;

	// configuration registers
	logic [ap3d_pkg::EXT_REG_W-1:0]  ext1_q, ext2_q, ext3_q;
	logic [ap3d_pkg::CH_REG_W-1:0]   nch_q;
	logic [ap3d_pkg::POOL_REG_W-1:0] pl1_q, pl2_q, pl3_q;
	logic                            cfg_hit;

	// clamped sizes
	logic [EW-1:0]  e1, e2, e3;
	logic [NCW-1:0] nc;
	logic [PLW-1:0] p1, p2, p3;

	// raster position
	logic [PW-1:0] pos1_q, pos2_q, pos3_q;
	logic [OW-1:0] off1_q, off2_q, off3_q;
	logic [PW-1:0] win2_q, win3_q;
	logic [CW-1:0] ch_q;

	logic last1, last2, last3, lastc, end1, end2, end3, wrap1, wrap2, wrap3;
	logic [EW-1:0]  left1, left2, left3;
	logic [PLW-1:0] pr1, pr2, pr3;

	ap3d_pkg::state_t state_q, state_d;
	logic accept;

	// item registers
	logic signed [ap3d_pkg::SAMPLE_W-1:0] sample_s1;
	logic                 first_s1, emit_s1, done_s1;
	logic [CW-1:0]        ch_s1;
	logic [AW-1:0]        addr_s1;
	logic [2*PLW-1:0]     n12_s1;
	logic [PLW-1:0]       pr3_s1;
	logic                 neg_q, done_q;
	logic [CW-1:0]        ch_q2;

	logic signed [SUM_W-1:0] sums_mem [2**AW];
	logic signed [SUM_W-1:0] rd_s1;
	logic signed [SUM_W-1:0] sum;
	logic [SUM_W-1:0]        mag;
	logic [NW-1:0]           n_cnt;
	logic                    div_start, div_done;
	logic [DW-1:0]           div_q;
	logic [ap3d_pkg::SAMPLE_W-1:0] qlo, res;

	logic        m_tvalid_q;
	logic [23:0] m_tdata_q;
	logic        m_tlast_q;
	logic        out_load;

	always_comb begin
		e1 = (ext1_q == '0) ? EW'(1) : (32'(ext1_q) > MAX_EXTENT) ? EW'(MAX_EXTENT) : EW'(ext1_q);
		e2 = (ext2_q == '0) ? EW'(1) : (32'(ext2_q) > MAX_EXTENT) ? EW'(MAX_EXTENT) : EW'(ext2_q);
		e3 = (ext3_q == '0) ? EW'(1) : (32'(ext3_q) > MAX_EXTENT) ? EW'(MAX_EXTENT) : EW'(ext3_q);
		nc = (nch_q == '0) ? NCW'(1)
			: (32'(nch_q) > MAX_CHANNELS) ? NCW'(MAX_CHANNELS) : NCW'(nch_q);
		p1 = (pl1_q == '0) ? PLW'(1) : (32'(pl1_q) > MAX_POOL) ? PLW'(MAX_POOL) : PLW'(pl1_q);
		p2 = (pl2_q == '0) ? PLW'(1) : (32'(pl2_q) > MAX_POOL) ? PLW'(MAX_POOL) : PLW'(pl2_q);
		p3 = (pl3_q == '0) ? PLW'(1) : (32'(pl3_q) > MAX_POOL) ? PLW'(MAX_POOL) : PLW'(pl3_q);
	end

	// window bounds at the current position
	always_comb begin
		end1 = (EW'(pos1_q) + EW'(1)) >= e1;
		end2 = (EW'(pos2_q) + EW'(1)) >= e2;
		end3 = (EW'(pos3_q) + EW'(1)) >= e3;
		wrap1 = (PLW'(off1_q) == p1 - PLW'(1));
		wrap2 = (PLW'(off2_q) == p2 - PLW'(1));
		wrap3 = (PLW'(off3_q) == p3 - PLW'(1));
		last1 = wrap1 || end1;
		last2 = wrap2 || end2;
		last3 = wrap3 || end3;
		lastc = (NCW'(ch_q) + NCW'(1)) >= nc;
		left1 = e1 - (EW'(pos1_q) - EW'(off1_q));
		left2 = e2 - (EW'(pos2_q) - EW'(off2_q));
		left3 = e3 - (EW'(pos3_q) - EW'(off3_q));
		pr1 = (32'(left1) < 32'(p1)) ? PLW'(left1) : p1;
		pr2 = (32'(left2) < 32'(p2)) ? PLW'(left2) : p2;
		pr3 = (32'(left3) < 32'(p3)) ? PLW'(left3) : p3;
	end

	assign accept = s_tvalid && s_tready;
	assign cfg_ready = (state_q == ap3d_pkg::ST_IDLE);
	assign cfg_hit = cfg_valid && cfg_ready && (cfg_index != ap3d_pkg::REG_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext1_q <= ap3d_pkg::EXT_RESET;
			ext2_q <= ap3d_pkg::EXT_RESET;
			ext3_q <= ap3d_pkg::EXT_RESET;
			nch_q <= ap3d_pkg::CH_RESET;
			pl1_q <= ap3d_pkg::POOL_RESET;
			pl2_q <= ap3d_pkg::POOL_RESET;
			pl3_q <= ap3d_pkg::POOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ap3d_pkg::reg_idx_t'(cfg_index))
				ap3d_pkg::REG_EXTENT_D1: ext1_q <= cfg_data;
				ap3d_pkg::REG_EXTENT_D2: ext2_q <= cfg_data;
				ap3d_pkg::REG_EXTENT_D3: ext3_q <= cfg_data;
				ap3d_pkg::REG_CHANNEL_COUNT: nch_q <= cfg_data[ap3d_pkg::CH_REG_W-1:0];
				ap3d_pkg::REG_POOL_D1: pl1_q <= cfg_data[ap3d_pkg::POOL_REG_W-1:0];
				ap3d_pkg::REG_POOL_D2: pl2_q <= cfg_data[ap3d_pkg::POOL_REG_W-1:0];
				ap3d_pkg::REG_POOL_D3: pl3_q <= cfg_data[ap3d_pkg::POOL_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// advance the raster position on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos1_q <= '0; pos2_q <= '0; pos3_q <= '0;
			off1_q <= '0; off2_q <= '0; off3_q <= '0;
			win2_q <= '0; win3_q <= '0; ch_q <= '0;
		end else if (cfg_hit) begin
			pos1_q <= '0; pos2_q <= '0; pos3_q <= '0;
			off1_q <= '0; off2_q <= '0; off3_q <= '0;
			win2_q <= '0; win3_q <= '0; ch_q <= '0;
		end else if (accept) begin
			if (!lastc) begin
				ch_q <= ch_q + 1'b1;
			end else begin
				ch_q <= '0;
				if (!end3) begin
					pos3_q <= pos3_q + 1'b1;
					off3_q <= wrap3 ? '0 : off3_q + 1'b1;
					win3_q <= wrap3 ? win3_q + 1'b1 : win3_q;
				end else begin
					pos3_q <= '0; off3_q <= '0; win3_q <= '0;
					if (!end2) begin
						pos2_q <= pos2_q + 1'b1;
						off2_q <= wrap2 ? '0 : off2_q + 1'b1;
						win2_q <= wrap2 ? win2_q + 1'b1 : win2_q;
					end else begin
						pos2_q <= '0; off2_q <= '0; win2_q <= '0;
						if (!end1) begin
							pos1_q <= pos1_q + 1'b1;
							off1_q <= wrap1 ? '0 : off1_q + 1'b1;
						end else begin
							pos1_q <= '0; off1_q <= '0;
						end
					end
				end
			end
		end
	end

	// capture the request and its window facts
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= s_tdata;
			first_s1 <= (off1_q == '0) && (off2_q == '0) && (off3_q == '0);
			emit_s1 <= last1 && last2 && last3;
			done_s1 <= end1 && end2 && end3 && lastc;
			ch_s1 <= ch_q;
			addr_s1 <= {win2_q, win3_q, ch_q};
			n12_s1 <= (2*PLW)'(pr1) * (2*PLW)'(pr2);
			pr3_s1 <= pr3;
		end
	end

	// sum memory: read on accept, write back in the accumulate cycle
	always_ff @(posedge clk) begin
		if (accept)
			rd_s1 <= sums_mem[{win2_q, win3_q, ch_q}];
		if (state_q == ap3d_pkg::ST_ACC)
			sums_mem[addr_s1] <= sum;
	end

	always_comb begin
		sum = first_s1 ? SUM_W'(sample_s1) : rd_s1 + SUM_W'(sample_s1);
		mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
		n_cnt = NW'(n12_s1) * NW'(pr3_s1);
	end

	assign div_start = (state_q == ap3d_pkg::ST_ACC) && emit_s1;

	always_ff @(posedge clk) begin
		if (div_start) begin
			neg_q <= sum[SUM_W-1];
			done_q <= done_s1;
			ch_q2 <= ch_s1;
		end
	end

	// round half away from zero: (2|s| + n) / 2n
	ap3d_div #(.DW(DW), .VW(VW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({mag, 1'b0} + DW'(n_cnt)),
		.divisor  ({n_cnt, 1'b0}),
		.done     (div_done),
		.quotient (div_q)
	);

	assign qlo = div_q[ap3d_pkg::SAMPLE_W-1:0];
	assign res = neg_q ? (~qlo + 1'b1) : qlo;
	assign out_load = (state_q == ap3d_pkg::ST_OUT) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ap3d_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			ap3d_pkg::ST_IDLE: begin
				s_tready = !(cfg_valid && cfg_index != ap3d_pkg::REG_NONE);
				if (accept)
					state_d = ap3d_pkg::ST_ACC;
			end
			ap3d_pkg::ST_ACC: state_d = emit_s1 ? ap3d_pkg::ST_DIV : ap3d_pkg::ST_IDLE;
			ap3d_pkg::ST_DIV: if (div_done) state_d = ap3d_pkg::ST_OUT;
			ap3d_pkg::ST_OUT: if (out_load) state_d = ap3d_pkg::ST_IDLE;
			default: state_d = ap3d_pkg::ST_IDLE;
		endcase
	end

	// output register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (out_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {4'd0, ap3d_pkg::CHAN_OUT_W'(ch_q2), res};
			m_tlast_q <= done_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tlast = m_tlast_q;

	ap_acc_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ap3d_pkg::ST_ACC) else $error("accept without accumulate");
	ap_no_emit_back: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ap3d_pkg::ST_ACC && !emit_s1) |=> state_q == ap3d_pkg::ST_IDLE)
		else $error("stuck after accumulate");
	ap_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ap3d_pkg::ST_DIV) else $error("divider done out of place");
	ap_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid_q || m_tready)) else $error("output overwritten");

endmodule

// ----- hdl/ap3d_div.sv -----
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle.
module ap3d_div #(
	parameter int DW = 26,
	parameter int VW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);
	localparam int CNTW = $clog2(DW + 1);

	logic [VW-1:0]   rem_q;
	logic [VW-1:0]   div_q;
	logic [DW-1:0]   quo_q;
	logic [CNTW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;
	logic [VW:0]     trial;
	logic            fits;
	logic [VW:0]     diff;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits = trial >= {1'b0, div_q};
	assign diff = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNTW'(DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? diff[VW-1:0] : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

	ap_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !run_q) else $error("divider restarted while busy");
	ap_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q && cnt_q == CNTW'(1)) |=> done_q) else $error("divider missed done");
	ap_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !run_q) else $error("done while running");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

	typedef struct packed {
		logic [15:0] pooled;
		logic [3:0]  chan;
		logic        done;
	} pool_out_t;

	// Scoreboard: tracks raster position and window sums, queues averages.
	class pool_scoreboard;
		int unsigned ext1, ext2, ext3, nchan, pl1, pl2, pl3;
		int unsigned p1, p2, p3, pc;
		int sums[int];
		pool_out_t pending[$];
		int errors;

		function new();
			ext1 = 8; ext2 = 8; ext3 = 8; nchan = 1; pl1 = 2; pl2 = 2; pl3 = 2;
			p1 = 0; p2 = 0; p3 = 0; pc = 0; errors = 0;
		endfunction

		function int unsigned sat(int unsigned v, int unsigned hi);
			if (v < 1) return 1;
			if (v > hi) return hi;
			return v;
		endfunction

		function int unsigned span(int unsigned pos, int unsigned pl, int unsigned ex);
			int unsigned left;
			left = ex - (pos - pos % pl);
			return (left < pl) ? left : pl;
		endfunction

		function void write_reg(ap3d_pkg::reg_idx_t idx, logic [6:0] val);
			case (idx)
				ap3d_pkg::REG_EXTENT_D1: ext1 = val;
				ap3d_pkg::REG_EXTENT_D2: ext2 = val;
				ap3d_pkg::REG_EXTENT_D3: ext3 = val;
				ap3d_pkg::REG_CHANNEL_COUNT: nchan = val[4:0];
				ap3d_pkg::REG_POOL_D1: pl1 = val[3:0];
				ap3d_pkg::REG_POOL_D2: pl2 = val[3:0];
				ap3d_pkg::REG_POOL_D3: pl3 = val[3:0];
				default: return;
			endcase
			p1 = 0; p2 = 0; p3 = 0; pc = 0;
		endfunction

		function void note_sample(logic signed [15:0] s);
			int unsigned e1, e2, e3, nc, q1, q2, q3, key, n;
			longint sum, mag, q;
			bit l1, l2, l3, lc;
			pool_out_t r;
			e1 = sat(ext1, 64); e2 = sat(ext2, 64); e3 = sat(ext3, 64);
			nc = sat(nchan, 16);
			q1 = sat(pl1, 8); q2 = sat(pl2, 8); q3 = sat(pl3, 8);
			key = ((p2 / q2) * 64 + p3 / q3) * 16 + pc;
			if (p1 % q1 == 0 && p2 % q2 == 0 && p3 % q3 == 0)
				sum = s;
			else
				sum = sums[key] + s;
			sums[key] = int'(sum);
			l1 = (p1 % q1 == q1 - 1) || (p1 + 1 >= e1);
			l2 = (p2 % q2 == q2 - 1) || (p2 + 1 >= e2);
			l3 = (p3 % q3 == q3 - 1) || (p3 + 1 >= e3);
			lc = (pc + 1 >= nc);
			if (l1 && l2 && l3) begin
				n = span(p1, q1, e1) * span(p2, q2, e2) * span(p3, q3, e3);
				mag = (sum < 0) ? -sum : sum;
				q = (2 * mag + n) / (2 * n);
				r.pooled = (sum < 0) ? 16'(-q) : 16'(q);
				r.chan = pc[3:0];
				r.done = (p1 + 1 >= e1) && (p2 + 1 >= e2) && (p3 + 1 >= e3) && lc;
				pending.insert(pending.size(), r);
			end
			// advance raster position, channel fastest
			if (!lc) pc++;
			else begin
				pc = 0;
				if (p3 + 1 < e3) p3++;
				else begin
					p3 = 0;
					if (p2 + 1 < e2) p2++;
					else begin
						p2 = 0;
						p1 = (p1 + 1 < e1) ? p1 + 1 : 0;
					end
				end
			end
		endfunction

		function void check_result(pool_out_t got);
			pool_out_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, actual %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.pooled !== want.pooled) begin
				$display("%0t: pooled_value expected %h actual %h", $time, want.pooled,
					got.pooled);
				errors++;
			end
			if (got.chan !== want.chan) begin
				$display("%0t: out_channel expected %0d actual %0d", $time, want.chan,
					got.chan);
				errors++;
			end
			if (got.done !== want.done) begin
				$display("%0t: volume_done expected %0d actual %0d", $time, want.done,
					got.done);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [6:0]  cfg_data = '0;

	pool_scoreboard sb = new();
	bit hold_off = 1'b0;
	bit quiet_rx = 1'b0;
	longint cycles = 0;

	average_pool_3d_stream uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Timeout guard: the divider path is slow, so leave ample margin.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("average_pool_3d_stream test failed");
			$finish;
		end
	end

	// Receiver: random stall pattern, with optional long hold-off and quiet spans.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result({m_tdata[15:0], m_tdata[19:16], m_tlast});
		if (hold_off) m_tready <= 1'b0;
		else if (quiet_rx) m_tready <= 1'b1;
		else m_tready <= ($urandom_range(0, 3) != 0);
	end

	// Send one configuration request and mirror it in the scoreboard.
	task automatic write_cfg(ap3d_pkg::reg_idx_t idx, logic [6:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic set_shape(int e1, int e2, int e3, int nc, int q1, int q2, int q3);
		write_cfg(ap3d_pkg::REG_EXTENT_D1, 7'(e1));
		write_cfg(ap3d_pkg::REG_EXTENT_D2, 7'(e2));
		write_cfg(ap3d_pkg::REG_EXTENT_D3, 7'(e3));
		write_cfg(ap3d_pkg::REG_CHANNEL_COUNT, 7'(nc));
		write_cfg(ap3d_pkg::REG_POOL_D1, 7'(q1));
		write_cfg(ap3d_pkg::REG_POOL_D2, 7'(q2));
		write_cfg(ap3d_pkg::REG_POOL_D3, 7'(q3));
		cfg_valid <= 1'b0;
	endtask

	// Offer one sample request; hold valid until accepted.
	task automatic send_sample(logic [15:0] v);
		s_tvalid <= 1'b1;
		s_tdata <= v;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_sample(v);
	endtask

	task automatic send_burst_gap();
		s_tvalid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Drain outputs, then let any in-flight divide finish before reconfiguring.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic run_random(int count);
		int burst;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 40);
				if ($urandom_range(0, 2) == 0) send_burst_gap();
			end
			send_sample(rand_sample());
			burst--;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: default shape, extreme samples; none completes a window, so no average is checked.
		send_sample(16'h7fff);
		send_sample(16'h7fff);
		send_sample(16'h8000);
		send_sample(16'h0001);
		send_sample(16'hffff);
		send_sample(16'h0000);
		send_sample(16'h8000);
		send_sample(16'h8000);
		drain();

		// Directed: unit pools, out-of-range values that saturate.
		set_shape(2, 1, 3, 17, 0, 9, 1);
		for (int i = 0; i < 12; i++) send_sample((i & 1) ? 16'h8000 : 16'h7fff);
		drain();

		// Pool larger than extent, a zero extent saturates to one.
		set_shape(0, 3, 127, 2, 8, 8, 15);
		quiet_rx = 1'b1;
		run_random(3 * 64 * 2 + 5);
		quiet_rx = 1'b0;
		drain();

		// Long receiver hold-off so the block backs up its input.
		set_shape(3, 2, 2, 1, 1, 1, 1);
		fork
			begin
				hold_off = 1'b1;
				repeat (200) @(posedge clk);
				hold_off = 1'b0;
			end
			run_random(40);
		join
		drain();

		// Random shapes, mostly small, with one large channel count.
		for (int ph = 0; ph < 12; ph++) begin
			if (ph == 11)
				set_shape($urandom_range(1, 4), $urandom_range(1, 4), 64, 16, 8, 8, 8);
			else
				set_shape($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 8),
					$urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4),
					$urandom_range(1, 4));
			run_random(ph == 11 ? 400 : 110);
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("average_pool_3d_stream test passed");
		else
			$display("average_pool_3d_stream test failed");
		$finish;
	end
endmodule

// ----- files.f -----
hdl/ap3d_pkg.sv
hdl/ap3d_div.sv
hdl/average_pool_3d_stream.sv
tb/tb_top.sv
